// File: design/prime_test_trial_division_macros.svh
// assertion macros for the asserting file, prime_test_trial_division
`ifndef PRIME_TEST_TRIAL_DIVISION_MACROS_SVH
`define PRIME_TEST_TRIAL_DIVISION_MACROS_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define PTD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define PTD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTD_ASSERT(lbl, clk, rst_n, prop, msg)
`define PTD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: design/ptd_pkg.sv
package ptd_pkg;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_DONE
    } t_state;

    localparam int FIRST_DIVISOR = 3;
    localparam int DIVISOR_STEP  = 2;
    localparam int SMALLEST_PRIME = 2;

endpackage

// File: design/ptd_divider.sv
module ptd_divider #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DATA_WIDTH-1:0] i_dividend,
    input  logic [DATA_WIDTH-1:0] i_divisor,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_quotient,
    output logic                  o_rem_zero
);

    localparam int CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_quo;
    logic [DATA_WIDTH-1:0] r_div;

    logic [DATA_WIDTH:0]   w_shift;
    logic [DATA_WIDTH:0]   w_diff;
    logic                  w_fits;

    // one restoring radix-2 step per cycle while busy
    assign w_shift = {r_rem, r_quo[DATA_WIDTH-1]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_fits  = (w_shift >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
            r_cnt <= CW'(DATA_WIDTH - 1);
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[DATA_WIDTH-1:0] : w_shift[DATA_WIDTH-1:0];
            r_quo <= {r_quo[DATA_WIDTH-2:0], w_fits};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
    assign o_rem_zero = (r_rem == '0);

endmodule

// File: design/prime_test_trial_division.sv
// values settled without division (zero, most negative, magnitudes up to 3, even
// magnitudes) go from idle straight to the done state; otherwise the shared divider
// runs once per odd trial divisor, up to about 23170 divisors for DATA_WIDTH = 32
// one item at a time: a new item is taken only after the result enters the output register
// reset: synchronous, active low; sequencer idle and no result pending
module prime_test_trial_division #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_prime_flag
);

    import ptd_pkg::*;

    `include "prime_test_trial_division_macros.svh"

    // sequencer state
    t_state r_state;
    t_state n_state;

    // trial division working registers
    logic [DATA_WIDTH-1:0] r_n;
    logic [DATA_WIDTH-1:0] n_n;
    logic [DATA_WIDTH-1:0] r_d;
    logic [DATA_WIDTH-1:0] n_d;
    logic [DATA_WIDTH-1:0] r_q;
    logic [DATA_WIDTH-1:0] n_q;
    logic                  r_res;
    logic                  n_res;

    // output register, parts the sequencer from the consumer
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic                  r_prime_flag;
    logic                  n_prime_flag;

    logic                  w_accept;
    logic                  w_out_free;
    logic [DATA_WIDTH-1:0] w_mag;
    logic                  w_trivial;
    logic                  w_trivial_res;
    logic                  w_d_le_q;

    logic                  div_start;
    logic                  div_done;
    logic [DATA_WIDTH-1:0] div_quo;
    logic                  div_rem_zero;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // magnitude; the most negative value maps onto itself, which is even and
    // so gives false, and zero falls under the small magnitudes
    assign w_mag = i_value[DATA_WIDTH-1] ? (~i_value + 1'b1) : i_value;

    // small magnitudes and even magnitudes need no division
    assign w_trivial     = (w_mag <= DATA_WIDTH'(FIRST_DIVISOR)) || !w_mag[0];
    assign w_trivial_res = (w_mag >= DATA_WIDTH'(SMALLEST_PRIME))
                        && (w_mag <= DATA_WIDTH'(FIRST_DIVISOR));

    // loop condition: keep trying while divisor does not exceed last quotient
    assign w_d_le_q = (r_d <= r_q);

    // the one shared divider, reused for every trial divisor
    ptd_divider #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_n),
        .i_divisor  (r_d),
        .o_done     (div_done),
        .o_quotient (div_quo),
        .o_rem_zero (div_rem_zero)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_trivial ? S_DONE : S_START;
                end
            end
            S_START: begin
                // divisors exhausted means prime
                n_state = w_d_le_q ? S_WAIT : S_DONE;
            end
            S_WAIT: begin
                if (div_done) begin
                    n_state = div_rem_zero ? S_DONE : S_START;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer outputs and datapath updates
    always_comb begin
        div_start    = 1'b0;
        n_n          = r_n;
        n_d          = r_d;
        n_q          = r_q;
        n_res        = r_res;
        n_out_valid  = r_out_valid;
        n_prime_flag = r_prime_flag;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_n   = w_mag;
                    n_d   = DATA_WIDTH'(FIRST_DIVISOR);
                    n_q   = w_mag;
                    n_res = w_trivial_res;
                end
            end
            S_START: begin
                div_start = w_d_le_q;
                if (!w_d_le_q) begin
                    n_res = 1'b1;
                end
            end
            S_WAIT: begin
                if (div_done) begin
                    if (div_rem_zero) begin
                        // exact division found a factor
                        n_res = 1'b0;
                    end else begin
                        n_q = div_quo;
                        n_d = r_d + DATA_WIDTH'(DIVISOR_STEP);
                    end
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase

        // output register: load the finished result, or empty when taken
        if (w_out_free) begin
            n_out_valid = (r_state == S_DONE);
            if (r_state == S_DONE) begin
                n_prime_flag = r_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n          <= n_n;
        r_d          <= n_d;
        r_q          <= n_q;
        r_res        <= n_res;
        r_prime_flag <= n_prime_flag;
    end

    assign o_out_valid  = r_out_valid;
    assign o_prime_flag = r_prime_flag;

    // trial divisors are always odd while a division is under way
    `PTD_ASSERT(a_divisor_odd, i_clk, i_rst_n, ((r_state == S_START) || (r_state == S_WAIT)) |-> r_d[0], "even trial divisor")
    // the divider only finishes while the sequencer waits for it
    `PTD_ASSERT(a_done_in_wait, i_clk, i_rst_n, div_done |-> (r_state == S_WAIT), "divider finished outside wait")
    // a new result comes only from the done state
    `PTD_ASSERT(a_result_source, i_clk, i_rst_n, $rose(o_out_valid) |-> ($past(r_state) == S_DONE), "result without done state")
    // reset empties the output register
    `PTD_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule
